// ===== rtl/aesc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console escape parser package
// Shared types, character codes and default geometry for the escape-sequence
// parser and its result queue.
// ----------------------------------------------------------------------------
package aesc_pkg;

    // default console geometry
    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 30;
    localparam int MAX_PARAMS_DEF = 4;
    localparam int TAB_STOP_DEF   = 8;

    // character codes
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_FINAL_LO  = 8'h40;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_QUEST     = 8'h3F;
    localparam logic [7:0] CH_FIN_CUP   = 8'h48;  // H
    localparam logic [7:0] CH_FIN_SET   = 8'h68;  // h
    localparam logic [7:0] CH_FIN_RESET = 8'h6C;  // l
    localparam logic [7:0] CH_FIN_ED    = 8'h4A;  // J
    localparam logic [7:0] CH_FIN_EL    = 8'h4B;  // K
    localparam logic [6:0] SEQ_START    = 7'h1B;  // ESC or 8-bit CSI with bit 7 masked

    localparam logic [3:0] CLS_INTER    = 4'h2;
    localparam logic [3:0] CLS_PARAM    = 4'h3;
    localparam logic [3:0] DIGIT_MAX    = 4'd9;

    localparam logic [15:0] PARAM_MAX   = 16'hFFFF;
    localparam logic [15:0] PARAM_TEN   = 16'd10;
    localparam logic [15:0] MODE_CURSOR = 16'd25;
    localparam logic [15:0] ED_ALL      = 16'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI
    } mode_t;

    typedef enum logic [2:0] {
        OP_MOVE,
        OP_GLYPH,
        OP_SCROLL,
        OP_CLEAR_SCREEN,
        OP_CLEAR_SPAN,
        OP_CURSOR_VIS
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] cell_addr;
        logic [7:0]  glyph;
        logic [6:0]  span_len;
        logic [11:0] cursor_pos;
        logic        cursor_visible;
        logic        last;
    } res_t;

    // results produced by one byte, handed to the result queue
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

// ===== rtl/aesc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console escape parser channels
// Byte channel into the parser and command channel out of it, both
// valid/ready.
// ----------------------------------------------------------------------------
interface aesc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface aesc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [11:0] cell_addr;
    logic [7:0]  glyph;
    logic [6:0]  span_len;
    logic [11:0] cursor_pos;
    logic        cursor_visible;
    logic        last;

    modport source (output valid, output op, output cell_addr, output glyph,
                    output span_len, output cursor_pos, output cursor_visible,
                    output last, input ready);
    modport sink   (input valid, input op, input cell_addr, input glyph,
                    input span_len, input cursor_pos, input cursor_visible,
                    input last, output ready);
endinterface

// ===== rtl/aesc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console escape parser step
// Input byte register, parse and cursor state, and the single-pass step that
// turns one byte into up to two command results.
// ----------------------------------------------------------------------------
module aesc_parser
    import aesc_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int TAB_STOP   = TAB_STOP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    aesc_in_if.sink    text,
    input  logic       room,
    output push_t      push
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int RW_W      = ROW_W + 1;
    localparam int PH_W      = $clog2(TAB_STOP);
    localparam int PI_W      = $clog2(MAX_PARAMS);
    localparam int WRAP_W    = COL_W + 2;
    localparam int COL_LAST  = COLUMNS - 1;
    localparam int ROW_LAST  = ROWS - 1;
    localparam int HOME_CELL = CELLS - COLUMNS;
    localparam int HOME_PH   = (CELLS - COLUMNS) % TAB_STOP;

    // tab phase of each column start and each row start
    logic [PH_W-1:0] col_phase [COLUMNS];
    logic [PH_W-1:0] row_phase [ROWS+1];

    genvar g;
    generate
        for (g = 0; g < COLUMNS; g++)
        begin : g_col_phase
            localparam int PH = g % TAB_STOP;
            assign col_phase[g] = PH_W'(PH);
        end
        for (g = 0; g <= ROWS; g++)
        begin : g_row_phase
            localparam int PH = (g * COLUMNS) % TAB_STOP;
            assign row_phase[g] = PH_W'(PH);
        end
    endgenerate

    // registers
    logic              hold_valid_reg;
    logic [7:0]        char_reg;
    mode_t             mode_reg, mode_next;
    logic [7:0]        inter_reg, inter_next;
    logic [PI_W-1:0]   pcount_reg, pcount_next;
    logic [15:0]       pval_reg  [MAX_PARAMS];
    logic [15:0]       pval_next [MAX_PARAMS];
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic              shown_reg, shown_next;

    logic              fire;
    logic [7:0]        c;
    logic              is_start;
    logic              csi_ignore;
    logic              is_digit;
    logic              is_semi;
    logic              is_inter;

    logic [PI_W-1:0]   pidx;
    logic [PI_W-1:0]   semi_base;
    logic [PI_W-1:0]   semi_count;
    logic [15:0]       scaled;
    logic [16:0]       dsum;
    logic [15:0]       digit_val;

    logic [PH_W:0]     tab_dist;
    logic [WRAP_W-1:0] tab_s0, tab_s1, tab_s2;
    logic              tab_w1, tab_w2;
    logic [1:0]        tab_wraps;
    logic [COL_W-1:0]  tab_col;

    logic [15:0]       p0, p1, x_full, y_full, p0_eff;
    logic [COL_W-1:0]  cup_col;
    logic [ROW_W-1:0]  cup_row;
    logic [CELL_W-1:0] cup_cell;
    logic [PH_W:0]     cup_psum;
    logic [PH_W-1:0]   cup_phase;
    logic              vis_match;
    logic [WRAP_W-1:0] span_full;

    logic [RW_W-1:0]   row_wide;
    logic [RW_W-1:0]   row_inc;
    logic [1:0]        n;
    res_t              r0, r1;

    assign fire       = hold_valid_reg && room;
    assign text.ready = !hold_valid_reg || room;
    assign c          = char_reg;

    // byte classes
    assign is_start   = (c[6:0] == SEQ_START);
    assign csi_ignore = (c <= CH_SPACE) || (c == CH_DEL);
    assign is_digit   = (c[7:4] == CLS_PARAM) && (c[3:0] <= DIGIT_MAX);
    assign is_semi    = (c == CH_SEMI);
    assign is_inter   = (c[7:4] == CLS_INTER)
                     || ((c[7:4] == CLS_PARAM) && !is_digit && !is_semi);

    // parameter accumulation
    assign pidx       = (pcount_reg == '0) ? '0 : PI_W'(pcount_reg - 1'b1);
    assign semi_base  = (pcount_reg == '0) ? PI_W'(1) : pcount_reg;
    assign semi_count = (semi_base < PI_W'(MAX_PARAMS - 1)) ? PI_W'(semi_base + 1'b1)
                                                           : semi_base;
    assign scaled     = pval_reg[pidx] * PARAM_TEN;
    assign dsum       = {1'b0, scaled} + {13'd0, c[3:0]};
    assign digit_val  = dsum[16] ? PARAM_MAX : dsum[15:0];

    // tab: distance to next stop, then wrap the column over at most two rows
    always_comb
    begin
        tab_dist  = (PH_W+1)'(TAB_STOP) - {1'b0, phase_reg};
        tab_s0    = WRAP_W'(col_reg) + WRAP_W'(tab_dist);
        tab_w1    = (tab_s0 >= WRAP_W'(COLUMNS));
        tab_s1    = tab_w1 ? WRAP_W'(tab_s0 - WRAP_W'(COLUMNS)) : tab_s0;
        tab_w2    = (tab_s1 >= WRAP_W'(COLUMNS));
        tab_s2    = tab_w2 ? WRAP_W'(tab_s1 - WRAP_W'(COLUMNS)) : tab_s1;
        tab_col   = tab_s2[COL_W-1:0];
        tab_wraps = {1'b0, tab_w1} + {1'b0, tab_w2};
    end

    // cursor position, visibility and erase-line operands
    assign p0     = pval_reg[0];
    assign p1     = pval_reg[1];
    assign x_full = (p1 == '0) ? '0 : 16'(p1 - 1'b1);
    assign y_full = (p0 == '0) ? '0 : 16'(p0 - 1'b1);

    always_comb
    begin
        cup_col   = (x_full >= 16'(COLUMNS)) ? COL_W'(COL_LAST) : x_full[COL_W-1:0];
        cup_row   = (y_full >= 16'(ROWS)) ? ROW_W'(ROW_LAST) : y_full[ROW_W-1:0];
        cup_cell  = CELL_W'(int'(cup_row) * COLUMNS + int'(cup_col));
        cup_psum  = {1'b0, row_phase[cup_row]} + {1'b0, col_phase[cup_col]};
        cup_phase = (cup_psum >= (PH_W+1)'(TAB_STOP))
                  ? PH_W'(cup_psum - (PH_W+1)'(TAB_STOP)) : cup_psum[PH_W-1:0];
    end

    assign p0_eff    = (p0 == '0) ? 16'd1 : p0;
    assign vis_match = (inter_reg == CH_QUEST) && (p0_eff == MODE_CURSOR);
    assign span_full = WRAP_W'(COLUMNS) - WRAP_W'(col_reg);
    assign row_inc   = RW_W'({1'b0, row_reg} + 1'b1);

    // parse mode transitions
    always_comb
    begin
        mode_next = mode_reg;
        if (is_start)
        begin
            mode_next = (c == CH_ESC) ? MODE_ESC : MODE_CSI;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESC:    mode_next = (c == CH_LBRACKET) ? MODE_CSI : MODE_NORMAL;
                MODE_CSI:
                begin
                    if (!csi_ignore && (c >= CH_FINAL_LO))
                        mode_next = MODE_NORMAL;
                end
                MODE_NORMAL: mode_next = MODE_NORMAL;
                default:     mode_next = MODE_NORMAL;
            endcase
        end
    end

    // datapath and results
    always_comb
    begin
        cell_next   = cell_reg;
        row_wide    = {1'b0, row_reg};
        col_next    = col_reg;
        phase_next  = phase_reg;
        shown_next  = shown_reg;
        inter_next  = inter_reg;
        pcount_next = pcount_reg;
        pval_next   = pval_reg;
        r0          = '0;
        r1          = '0;
        n           = 2'd0;

        if (is_start)
        begin
            inter_next  = '0;
            pcount_next = '0;
            for (int k = 0; k < MAX_PARAMS; k++)
                pval_next[k] = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    if (c == CH_LBRACKET)
                    begin
                        inter_next  = '0;
                        pcount_next = '0;
                        for (int k = 0; k < MAX_PARAMS; k++)
                            pval_next[k] = '0;
                    end
                end
                MODE_CSI:
                begin
                    if (!csi_ignore)
                    begin
                        priority if (is_inter)
                        begin
                            inter_next = c;
                        end
                        else if (is_digit)
                        begin
                            pcount_next     = semi_base;
                            pval_next[pidx] = digit_val;
                        end
                        else if (is_semi)
                        begin
                            pcount_next = semi_count;
                        end
                        else if (c == CH_FIN_CUP)
                        begin
                            cell_next  = cup_cell;
                            row_wide   = {1'b0, cup_row};
                            col_next   = cup_col;
                            phase_next = cup_phase;
                            r0.op      = OP_MOVE;
                            n          = 2'd1;
                        end
                        else if ((c == CH_FIN_SET) || (c == CH_FIN_RESET))
                        begin
                            if (vis_match)
                            begin
                                shown_next = (c == CH_FIN_SET);
                                r0.op      = OP_CURSOR_VIS;
                                n          = 2'd1;
                            end
                        end
                        else if (c == CH_FIN_ED)
                        begin
                            if (p0 == ED_ALL)
                            begin
                                r0.op = OP_CLEAR_SCREEN;
                                n     = 2'd1;
                            end
                        end
                        else if (c == CH_FIN_EL)
                        begin
                            r0.op        = OP_CLEAR_SPAN;
                            r0.cell_addr = 12'(cell_reg);
                            r0.span_len  = span_full[6:0];
                            n            = 2'd1;
                        end
                        else
                        begin
                            // unsupported final: drop the sequence quietly
                        end
                    end
                end
                MODE_NORMAL:
                begin
                    n = 2'd1;
                    unique case (c)
                        CH_CR:
                        begin
                            col_next   = '0;
                            cell_next  = CELL_W'(cell_reg - CELL_W'(col_reg));
                            phase_next = row_phase[row_reg];
                        end
                        CH_LF:
                        begin
                            row_wide   = row_inc;
                            col_next   = '0;
                            cell_next  = CELL_W'(cell_reg - CELL_W'(col_reg)
                                                 + CELL_W'(COLUMNS));
                            phase_next = row_phase[row_inc[ROW_W-1:0]];
                        end
                        CH_BS:
                        begin
                            if (cell_reg != '0)
                            begin
                                cell_next  = CELL_W'(cell_reg - 1'b1);
                                phase_next = (phase_reg == '0) ? PH_W'(TAB_STOP - 1)
                                                               : PH_W'(phase_reg - 1'b1);
                                if (col_reg == '0)
                                begin
                                    col_next = COL_W'(COL_LAST);
                                    row_wide = RW_W'({1'b0, row_reg} - 1'b1);
                                end
                                else
                                begin
                                    col_next = COL_W'(col_reg - 1'b1);
                                end
                            end
                        end
                        CH_TAB:
                        begin
                            cell_next  = CELL_W'(cell_reg + CELL_W'(tab_dist));
                            phase_next = '0;
                            col_next   = tab_col;
                            row_wide   = RW_W'({1'b0, row_reg} + RW_W'(tab_wraps));
                        end
                        CH_DEL:
                        begin
                            r0.op = OP_MOVE;
                        end
                        default:
                        begin
                            r0.op        = OP_GLYPH;
                            r0.cell_addr = 12'(cell_reg);
                            r0.glyph     = c;
                            cell_next    = CELL_W'(cell_reg + 1'b1);
                            phase_next   = (phase_reg == PH_W'(TAB_STOP - 1))
                                         ? '0 : PH_W'(phase_reg + 1'b1);
                            if (col_reg == COL_W'(COL_LAST))
                            begin
                                col_next = '0;
                                row_wide = row_inc;
                            end
                            else
                            begin
                                col_next = COL_W'(col_reg + 1'b1);
                            end
                        end
                    endcase
                    // past the last cell: scroll and home to the bottom row
                    if (row_wide >= RW_W'(ROWS))
                    begin
                        r1.op      = OP_SCROLL;
                        n          = 2'd2;
                        cell_next  = CELL_W'(HOME_CELL);
                        row_wide   = RW_W'(ROW_LAST);
                        col_next   = '0;
                        phase_next = PH_W'(HOME_PH);
                    end
                end
                default: ;
            endcase
        end
        row_next = row_wide[ROW_W-1:0];
    end

    // stamp cursor state and end marks onto the results
    always_comb
    begin
        push.count                 = fire ? n : 2'd0;
        push.first                 = r0;
        push.first.cursor_pos      = 12'(cell_next);
        push.first.cursor_visible  = shown_next;
        push.first.last            = (n == 2'd1);
        push.second                = r1;
        push.second.cursor_pos     = 12'(cell_next);
        push.second.cursor_visible = shown_next;
        push.second.last           = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
            char_reg <= text.char_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            inter_reg  <= '0;
            pcount_reg <= '0;
            for (int k = 0; k < MAX_PARAMS; k++)
                pval_reg[k] <= '0;
            cell_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            phase_reg  <= '0;
            shown_reg  <= 1'b1;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            inter_reg  <= inter_next;
            pcount_reg <= pcount_next;
            pval_reg   <= pval_next;
            cell_reg   <= cell_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            phase_reg  <= phase_next;
            shown_reg  <= shown_next;
        end
    end

endmodule

// ===== rtl/aesc_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console escape parser result queue
// Three-entry shift queue; takes one or two results per byte and presents
// one word per cycle from a register while cmd.ready is high.
// ----------------------------------------------------------------------------
module aesc_outq
    import aesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  push_t      push,
    output logic       room,
    aesc_out_if.source cmd
);

    localparam int DEPTH = 3;

    res_t       entry_reg  [DEPTH];
    res_t       entry_next [DEPTH];
    logic [1:0] count_reg, count_next;
    logic [1:0] level;
    logic       pop;

    assign pop   = (count_reg != '0) && cmd.ready;
    assign level = count_reg - {1'b0, pop};
    // leave space for a full pair
    assign room  = (count_reg <= 2'd1);

    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            entry_next[k] = (pop && (k < DEPTH - 1)) ? entry_reg[(k + 1) % DEPTH]
                                                     : entry_reg[k];
            if ((push.count != 2'd0) && (level == 2'(k)))
                entry_next[k] = push.first;
            if ((push.count == 2'd2) && (2'(level + 1'b1) == 2'(k)))
                entry_next[k] = push.second;
        end
        count_next = level + push.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign cmd.valid          = (count_reg != '0);
    assign cmd.op             = entry_reg[0].op;
    assign cmd.cell_addr      = entry_reg[0].cell_addr;
    assign cmd.glyph          = entry_reg[0].glyph;
    assign cmd.span_len       = entry_reg[0].span_len;
    assign cmd.cursor_pos     = entry_reg[0].cursor_pos;
    assign cmd.cursor_visible = entry_reg[0].cursor_visible;
    assign cmd.last           = entry_reg[0].last;

endmodule

// ===== rtl/ansi_terminal_escape_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console escape parser
// Interprets a console byte stream (controls, glyphs, ESC and CSI sequences)
// and emits cursor, glyph, scroll and clear commands.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     words per byte
//  text     in   char_code                                   1
//  cmd      out  op cell_addr glyph span_len cursor_pos      0, 1 or 2
//                cursor_visible last
//
//  One byte per cycle while the queue has room: a byte waits in the input
//  register while the parse and cursor step runs, and its results land in
//  a three-entry queue. A byte giving two results (glyph or move plus
//  scroll) leaves as two words; results wait in the queue register.
//  text.ready drops only when two or more results wait in the queue.
//  Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ansi_terminal_escape_parser_core
    import aesc_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAX_PARAMS = MAX_PARAMS_DEF,
    parameter int TAB_STOP   = TAB_STOP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    aesc_in_if.sink    text,
    aesc_out_if.source cmd
);

    localparam int HOME_CELL = COLUMNS * ROWS - COLUMNS;

    push_t push;
    logic  room;

    aesc_parser #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_PARAMS (MAX_PARAMS),
        .TAB_STOP   (TAB_STOP)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .room  (room),
        .push  (push)
    );

    aesc_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .cmd   (cmd)
    );

`ifndef SYNTH
    // a scroll always closes its byte and homes the cursor to the bottom row
    a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.op == OP_SCROLL)) |-> cmd.last)
        else $error("scroll result not marked last");

    a_scroll_home: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.op == OP_SCROLL)) |-> (cmd.cursor_pos == 12'(HOME_CELL)))
        else $error("scroll left cursor off the bottom row start");

    a_span_at_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && (cmd.op == OP_CLEAR_SPAN)) |-> (cmd.cell_addr == cmd.cursor_pos))
        else $error("erase span does not start at the cursor");

    // the partner of a non-final result is already queued behind it
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !cmd.last) |=> cmd.valid)
        else $error("second result of a byte missing");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console escape parser testbench
// Feeds directed and random console byte streams (text, controls, CSI and ESC
// sequences, noise) through the byte channel with random idling on both
// sides. A console model predicts the command words for every accepted byte
// and checks each command word taken from the output channel in order.
// ----------------------------------------------------------------------------
module tb;
    import aesc_pkg::*;

    localparam logic [7:0] CH_CSI8    = 8'h9B;
    localparam logic [7:0] CH_FIN_SGR = 8'h6D;  // m, not handled by the block
    localparam int         CELLS      = COLUMNS_DEF * ROWS_DEF;
    localparam int         HOLD_LONG  = 300;

    // ------------------------------------------------------------------------
    // console model: parse state, cursor and the command words still due
    // ------------------------------------------------------------------------
    class console_model;
        mode_t       mode;
        logic [7:0]  inter;
        int          npar;
        logic [15:0] par [MAX_PARAMS_DEF];
        int          cur;
        bit          shown;
        res_t        fresh [$];
        res_t        cmd_due [$];
        int          mismatches;

        function new();
            start_seq(MODE_NORMAL);
            cur        = 0;
            shown      = 1'b1;
            mismatches = 0;
        endfunction

        function void start_seq(mode_t m);
            mode  = m;
            inter = '0;
            npar  = 0;
            foreach (par[i])
                par[i] = '0;
        endfunction

        function void add(op_t op, int addr, logic [7:0] g, int span);
            res_t r;
            r           = '0;
            r.op        = op;
            r.cell_addr = addr[11:0];
            r.glyph     = g;
            r.span_len  = span[6:0];
            fresh.push_back(r);
        endfunction

        function void plain(logic [7:0] c);
            if (c == CH_CR) begin
                cur -= cur % COLUMNS_DEF;
                add(OP_MOVE, 0, 8'h00, 0);
            end else if (c == CH_LF) begin
                cur += COLUMNS_DEF;
                cur -= cur % COLUMNS_DEF;
                add(OP_MOVE, 0, 8'h00, 0);
            end else if (c == CH_BS) begin
                if (cur > 0)
                    cur--;
                add(OP_MOVE, 0, 8'h00, 0);
            end else if (c == CH_TAB) begin
                cur += TAB_STOP_DEF;
                cur -= cur % TAB_STOP_DEF;
                add(OP_MOVE, 0, 8'h00, 0);
            end else if (c == CH_DEL) begin
                add(OP_MOVE, 0, 8'h00, 0);
            end else begin
                add(OP_GLYPH, cur, c, 0);
                cur++;
            end
            // past the last cell: scroll and park on the bottom row
            if (cur >= CELLS) begin
                cur = CELLS - COLUMNS_DEF;
                add(OP_SCROLL, 0, 8'h00, 0);
            end
        endfunction

        function void finish_seq(logic [7:0] c);
            int p0;
            int p1;
            int x;
            int y;
            p0   = int'(par[0]);
            p1   = int'(par[1]);
            mode = MODE_NORMAL;
            if (c == CH_FIN_CUP) begin
                x = (p1 != 0) ? p1 - 1 : 0;
                y = (p0 != 0) ? p0 - 1 : 0;
                if (x >= COLUMNS_DEF)
                    x = COLUMNS_DEF - 1;
                if (y >= ROWS_DEF)
                    y = ROWS_DEF - 1;
                cur = y * COLUMNS_DEF + x;
                add(OP_MOVE, 0, 8'h00, 0);
            end else if (c == CH_FIN_SET || c == CH_FIN_RESET) begin
                if (inter == CH_QUEST && ((p0 != 0) ? p0 : 1) == int'(MODE_CURSOR)) begin
                    shown = (c == CH_FIN_SET);
                    add(OP_CURSOR_VIS, 0, 8'h00, 0);
                end
            end else if (c == CH_FIN_ED) begin
                if (p0 == int'(ED_ALL))
                    add(OP_CLEAR_SCREEN, 0, 8'h00, 0);
            end else if (c == CH_FIN_EL) begin
                add(OP_CLEAR_SPAN, cur, 8'h00, COLUMNS_DEF - cur % COLUMNS_DEF);
            end
        endfunction

        function void csi(logic [7:0] c);
            int idx;
            int v;
            if (c <= CH_SPACE || c == CH_DEL)
                return;
            if (c[7:4] == CLS_INTER) begin
                inter = c;
            end else if (c[7:4] == CLS_PARAM) begin
                if (c[3:0] <= DIGIT_MAX) begin
                    if (npar == 0)
                        npar = 1;
                    idx = npar - 1;
                    if (idx >= MAX_PARAMS_DEF)
                        idx = MAX_PARAMS_DEF - 1;
                    // wrap the multiply, saturate the add
                    v = (int'(par[idx]) * int'(PARAM_TEN)) % 65536 + int'(c[3:0]);
                    if (v > int'(PARAM_MAX))
                        v = int'(PARAM_MAX);
                    par[idx] = v[15:0];
                end else if (c == CH_SEMI) begin
                    if (npar == 0)
                        npar = 1;
                    if (npar < MAX_PARAMS_DEF - 1)
                        npar++;
                end else begin
                    inter = c;
                end
            end else begin
                finish_seq(c);
            end
        endfunction

        function void take_byte(logic [7:0] c);
            fresh.delete();
            if (c[6:0] == SEQ_START) begin
                start_seq((c == CH_ESC) ? MODE_ESC : MODE_CSI);
                return;
            end
            case (mode)
                MODE_ESC:
                begin
                    mode = MODE_NORMAL;
                    if (c == CH_LBRACKET)
                        start_seq(MODE_CSI);
                end
                MODE_CSI: csi(c);
                default:  plain(c);
            endcase
            foreach (fresh[i])
            begin
                fresh[i].cursor_pos     = cur[11:0];
                fresh[i].cursor_visible = shown;
                fresh[i].last           = (i == fresh.size() - 1);
                cmd_due.push_back(fresh[i]);
            end
        endfunction

        function string show(res_t r);
            return $sformatf("op=%0d addr=%0d glyph=%02h span=%0d cur=%0d vis=%0d last=%0d",
                             r.op, r.cell_addr, r.glyph, r.span_len, r.cursor_pos,
                             r.cursor_visible, r.last);
        endfunction

        function void match_cmd(res_t got);
            res_t want;
            if (cmd_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected command word: %s", $realtime, show(got));
                return;
            end
            want = cmd_due.pop_front();
            if (got.op !== want.op || got.cell_addr !== want.cell_addr ||
                got.glyph !== want.glyph || got.span_len !== want.span_len ||
                got.cursor_pos !== want.cursor_pos ||
                got.cursor_visible !== want.cursor_visible || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: command mismatch\n  expected %s\n  actual   %s",
                             $realtime, show(want), show(got));
            end
        endfunction

        function int pending();
            return cmd_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    aesc_in_if  text_if ();
    aesc_out_if cmd_if ();

    ansi_terminal_escape_parser_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .cmd   (cmd_if)
    );

    console_model book;
    logic [7:0]   stim [$];
    bit           tx_calm;
    bit           rx_calm;
    bit           hold_req;
    bit           rx_holding;
    res_t         seen;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("** ansi_terminal_escape_parser_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void queue_byte(logic [7:0] c);
        stim.push_back(c);
    endfunction

    function automatic void queue_num(int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            stim.push_back(s[i]);
    endfunction

    function automatic void queue_intro();
        if ($urandom_range(0, 1) == 0) begin
            queue_byte(CH_CSI8);
        end else begin
            queue_byte(CH_ESC);
            queue_byte(CH_LBRACKET);
        end
    endfunction

    function automatic int pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        else if (r < 75)
            return $urandom_range(1, 35);
        else if (r < 90)
            return $urandom_range(36, 120);
        else
            return $urandom_range(0, 70000);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            c = 8'($urandom_range(32, 126));
        end else if (r < 85) begin
            case ($urandom_range(0, 4))
                0:       c = CH_CR;
                1:       c = CH_LF;
                2:       c = CH_BS;
                3:       c = CH_TAB;
                default: c = CH_DEL;
            endcase
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        // keep runs free of sequence starts
        if (c[6:0] == SEQ_START)
            c[0] = 1'b0;
        return c;
    endfunction

    function automatic void add_chunk();
        int         r;
        int         n;
        logic [7:0] fin;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 12);
            repeat (n) queue_byte(pick_text_byte());
        end else if (r < 50) begin
            queue_intro();
            if ($urandom_range(0, 4) != 0)
                queue_num(pick_param());
            if ($urandom_range(0, 4) != 0) begin
                queue_byte(CH_SEMI);
                queue_num(pick_param());
            end
            queue_byte(CH_FIN_CUP);
        end else if (r < 56) begin
            repeat ($urandom_range(1, 5)) queue_byte(CH_LF);
        end else if (r < 64) begin
            queue_intro();
            if ($urandom_range(0, 5) != 0)
                queue_byte(CH_QUEST);
            if ($urandom_range(0, 4) != 0)
                queue_num(int'(MODE_CURSOR));
            else if ($urandom_range(0, 1) == 0)
                queue_num(pick_param());
            queue_byte(($urandom_range(0, 1) == 0) ? CH_FIN_SET : CH_FIN_RESET);
        end else if (r < 70) begin
            queue_intro();
            if ($urandom_range(0, 2) != 0)
                queue_num(int'(ED_ALL));
            else if ($urandom_range(0, 1) == 0)
                queue_num(pick_param());
            queue_byte(CH_FIN_ED);
        end else if (r < 76) begin
            queue_intro();
            if ($urandom_range(0, 1) == 0)
                queue_num(pick_param());
            queue_byte(CH_FIN_EL);
        end else if (r < 84) begin
            queue_intro();
            repeat ($urandom_range(0, 4)) queue_byte(8'($urandom_range(0, 8'h3F)));
            queue_byte(8'($urandom_range(8'h40, 8'hFF)));
        end else if (r < 92) begin
            queue_intro();
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 2) != 0)
                    queue_num(pick_param());
                queue_byte(CH_SEMI);
            end
            if ($urandom_range(0, 1) == 0)
                queue_num(pick_param());
            case ($urandom_range(0, 4))
                0:       fin = CH_FIN_CUP;
                1:       fin = CH_FIN_ED;
                2:       fin = CH_FIN_EL;
                3:       fin = CH_FIN_SET;
                default: fin = CH_FIN_SGR;
            endcase
            queue_byte(fin);
        end else if (r < 96) begin
            queue_byte(CH_ESC);
            queue_byte(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic wait_drained();
        @(negedge clk);
        text_if.valid <= 1'b0;
        while (book.pending() != 0)
            @(negedge clk);
    endtask

    task automatic send_bytes(int hold_at, int pause_at);
        int g;
        for (int i = 0; i < stim.size(); i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                wait_drained();
            if (i % 48 == 0) begin
                tx_calm = ($urandom_range(0, 4) == 0);
                rx_calm = ($urandom_range(0, 4) == 0);
            end
            // keep offering while the receiver holds off
            g = pick_gap(tx_calm || rx_holding);
            @(negedge clk);
            if (g > 0) begin
                text_if.valid <= 1'b0;
                repeat (g) @(negedge clk);
            end
            text_if.valid     <= 1'b1;
            text_if.char_code <= stim[i];
            @(posedge clk);
            while (!text_if.ready)
                @(posedge clk);
        end
        @(negedge clk);
        text_if.valid <= 1'b0;
        stim.delete();
    endtask

    initial
    begin
        int g;
        cmd_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                hold_req      = 1'b0;
                rx_holding    = 1'b1;
                cmd_if.ready <= 1'b0;
                repeat (HOLD_LONG) @(negedge clk);
                rx_holding    = 1'b0;
            end else begin
                g = pick_gap(rx_calm);
                if (g == 0) begin
                    cmd_if.ready <= 1'b1;
                end else begin
                    cmd_if.ready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && text_if.valid && text_if.ready)
            book.take_byte(text_if.char_code);
    end

    always @(posedge clk)
    begin
        if (rst_n && cmd_if.valid && cmd_if.ready) begin
            seen.op             = op_t'(cmd_if.op);
            seen.cell_addr      = cmd_if.cell_addr;
            seen.glyph          = cmd_if.glyph;
            seen.span_len       = cmd_if.span_len;
            seen.cursor_pos     = cmd_if.cursor_pos;
            seen.cursor_visible = cmd_if.cursor_visible;
            seen.last           = cmd_if.last;
            book.match_cmd(seen);
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        book              = new();
        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.char_code = 8'h00;
        tx_calm           = 1'b0;
        rx_calm           = 1'b0;
        hold_req          = 1'b0;
        rx_holding        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // controls, glyph extremes, backspace at the origin
        queue_byte(CH_BS);
        queue_byte(8'h41);
        queue_byte(CH_TAB);
        queue_byte(CH_DEL);
        queue_byte(CH_LF);
        queue_byte(CH_CR);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        // hide cursor via 8-bit CSI
        queue_byte(CH_CSI8);
        queue_byte(CH_QUEST);
        queue_num(int'(MODE_CURSOR));
        queue_byte(CH_FIN_RESET);
        // saturated row and over-wide column clamp to the last cell
        queue_byte(CH_CSI8);
        queue_num(65539);
        queue_byte(CH_SEMI);
        queue_num(99);
        queue_byte(CH_FIN_CUP);
        // glyph in the last cell scrolls
        queue_byte(8'h5A);
        queue_byte(CH_CSI8);
        queue_byte(CH_FIN_EL);
        queue_byte(CH_CSI8);
        queue_num(int'(ED_ALL));
        queue_byte(CH_FIN_ED);
        queue_byte(CH_ESC);
        queue_byte(CH_LBRACKET);
        queue_byte(CH_QUEST);
        queue_num(int'(MODE_CURSOR));
        queue_byte(CH_FIN_SET);
        send_bytes(-1, -1);
        wait_drained();

        while (stim.size() < 700)
            add_chunk();
        send_bytes(150, 420);
        wait_drained();
        repeat (10) @(posedge clk);

        if (book.mismatches == 0 && book.pending() == 0)
            $display("** ansi_terminal_escape_parser_core: PASSED **");
        else
            $display("** ansi_terminal_escape_parser_core: FAILED **");
        $finish;
    end

endmodule
